/* src/psfp_pkg.sv */
// Package for the particulate sensor frame parser.
// Holds frame constants, payload types and the decimal helper functions.
// No dependencies; every other file uses it.
`default_nettype none

package psfp_pkg;

  localparam int unsigned FRAME_BYTES = 32;   // legal range 12..64
  localparam int unsigned POS_W       = 6;
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] CKHI_POS = POS_W'(FRAME_BYTES - 2);

  localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_HDR2   = POS_W'(1);
  localparam logic [POS_W-1:0] POS_PM25_H = POS_W'(6);
  localparam logic [POS_W-1:0] POS_PM25_L = POS_W'(7);
  localparam logic [POS_W-1:0] POS_PM10_H = POS_W'(8);
  localparam logic [POS_W-1:0] POS_PM10_L = POS_W'(9);

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  // ceil(2^24 / 100); exact quotient for every 16-bit dividend
  localparam logic [17:0] RECIP_100 = 18'd167773;
  // floor(x * 205 / 2^11) == x / 10 for x < 1029
  localparam logic [7:0]  RECIP_10  = 8'd205;

  typedef struct packed {
    logic [15:0] pm25_value;
    logic [15:0] pm10_value;
    logic        checksum_ok;
    logic [15:0] received_sum;
    logic [15:0] computed_sum;
    logic [9:0]  pm25_hundreds;
    logic [3:0]  pm25_tens;
    logic [3:0]  pm25_ones;
    logic [9:0]  pm10_hundreds;
    logic [3:0]  pm10_tens;
    logic [3:0]  pm10_ones;
  } psfp_result_t;

  // Frame record handed from the parser to the digit stage.
  typedef struct packed {
    logic [15:0] pm25;
    logic [15:0] pm10;
    logic [9:0]  pm25_hund;
    logic [9:0]  pm10_hund;
    logic [15:0] rec_sum;
    logic [15:0] calc_sum;
    logic        sum_ok;
  } psfp_frame_t;

  typedef struct packed {
    logic [3:0] tens;
    logic [3:0] ones;
  } psfp_digits_t;

  function automatic logic [9:0] div100_f(input logic [15:0] val);
    logic [33:0] prod;
    prod = 34'(val) * 34'(RECIP_100);
    return prod[33:24];
  endfunction

  // Tens and ones from a value and its quotient by 100.
  function automatic psfp_digits_t split_rem_f(input logic [15:0] val,
                                               input logic [9:0]  quo);
    logic [16:0]  q100;
    logic [16:0]  diff;
    logic [6:0]   rem;
    logic [14:0]  prod;
    logic [3:0]   tens;
    logic [6:0]   t10;
    psfp_digits_t res;
    q100 = {1'b0, quo, 6'b0} + {2'b0, quo, 5'b0} + {5'b0, quo, 2'b0};
    diff = {1'b0, val} - q100;
    rem  = diff[6:0];
    prod = 15'(rem) * 15'(RECIP_10);
    tens = prod[14:11];
    t10  = {tens, 3'b0} + {2'b0, tens, 1'b0};
    res.tens = tens;
    res.ones = 4'(rem - t10);
    return res;
  endfunction

endpackage

`default_nettype wire

/* src/psfp_if.sv */
// Handshake interfaces for the frame parser: serial byte in, frame result out.
// Depends on psfp_pkg for the result payload type.
`default_nettype none

interface psfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface psfp_result_if;
  logic                  valid;
  logic                  ready;
  psfp_pkg::psfp_result_t result;

  modport source (output valid, output result, input ready);
  modport sink   (input valid, input result, output ready);
endinterface

`default_nettype wire

/* src/psfp_parser.sv */
// Byte-level frame parser: header hunt, checksum sum, word capture.
// Registers a frame record (with quotients by 100) on the last byte. Uses psfp_pkg.
`default_nettype none

module psfp_parser (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  psfp_byte_if.sink            rx_i,
  output logic                 frm_valid_o,
  input  wire                  frm_ready_i,
  output psfp_pkg::psfp_frame_t frm_o
);
  import psfp_pkg::*;

  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      sum_q, sum_d;
  logic [15:0]      pm25_q, pm25_d;
  logic [15:0]      pm10_q, pm10_d;
  logic [7:0]       ckhi_q, ckhi_d;
  logic             frm_valid_q, frm_valid_d;
  psfp_frame_t      frm_q, frm_d;
  logic             acc;
  logic             load;
  logic [7:0]       b;
  logic [15:0]      rec;

  assign rx_i.ready = !frm_valid_q || frm_ready_i;
  assign acc        = rx_i.valid && rx_i.ready;
  assign b          = rx_i.rx_byte;
  assign rec        = {ckhi_q, b};

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    pm25_d = pm25_q;
    pm10_d = pm10_q;
    ckhi_d = ckhi_q;
    load   = 1'b0;
    if (acc) begin
      if (pos_q == POS_HUNT) begin
        if (b == HDR_FIRST) begin
          pos_d  = POS_HDR2;
          sum_d  = 16'(HDR_FIRST);
          pm25_d = '0;
          pm10_d = '0;
          ckhi_d = '0;
        end
      end else if (pos_q == POS_HDR2) begin
        if (b == HDR_SECOND) begin
          sum_d = sum_q + 16'(b);
          pos_d = pos_q + POS_W'(1);
        end else begin
          // a repeated first header byte restarts the frame
          pos_d  = (b == HDR_FIRST) ? POS_HDR2 : POS_HUNT;
          sum_d  = (b == HDR_FIRST) ? 16'(HDR_FIRST) : '0;
          pm25_d = '0;
          pm10_d = '0;
          ckhi_d = '0;
        end
      end else if (pos_q < CKHI_POS) begin
        sum_d = sum_q + 16'(b);
        if (pos_q == POS_PM25_H) pm25_d[15:8] = b;
        if (pos_q == POS_PM25_L) pm25_d[7:0]  = b;
        if (pos_q == POS_PM10_H) pm10_d[15:8] = b;
        if (pos_q == POS_PM10_L) pm10_d[7:0]  = b;
        pos_d = pos_q + POS_W'(1);
      end else if (pos_q == CKHI_POS) begin
        ckhi_d = b;
        pos_d  = pos_q + POS_W'(1);
      end else begin
        load   = 1'b1;
        pos_d  = POS_HUNT;
        sum_d  = '0;
        pm25_d = '0;
        pm10_d = '0;
        ckhi_d = '0;
      end
    end
  end

  always_comb begin
    frm_d.pm25      = pm25_q;
    frm_d.pm10      = pm10_q;
    frm_d.pm25_hund = div100_f(pm25_q);
    frm_d.pm10_hund = div100_f(pm10_q);
    frm_d.rec_sum   = rec;
    frm_d.calc_sum  = sum_q;
    frm_d.sum_ok    = (rec == sum_q);
  end

  always_comb begin
    frm_valid_d = frm_valid_q;
    if (load) begin
      frm_valid_d = 1'b1;
    end else if (frm_ready_i) begin
      frm_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= POS_HUNT;
      sum_q       <= '0;
      pm25_q      <= '0;
      pm10_q      <= '0;
      ckhi_q      <= '0;
      frm_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      pm25_q      <= pm25_d;
      pm10_q      <= pm10_d;
      ckhi_q      <= ckhi_d;
      frm_valid_q <= frm_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frm_q <= frm_d;
    end
  end

  assign frm_valid_o = frm_valid_q;
  assign frm_o       = frm_q;

`ifndef NO_ASSERTIONS
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= LAST_POS)
    else $error("frame position past last byte");

  a_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && pos_q == LAST_POS) |=> (pos_q == POS_HUNT && frm_valid_q))
    else $error("last byte did not close the frame");

  a_hunt_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == POS_HUNT) |-> (sum_q == '0 && pm25_q == '0 && pm10_q == '0))
    else $error("state not cleared while hunting");

  a_hdr_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pos_q == POS_HDR2) |-> (sum_q == 16'(HDR_FIRST)))
    else $error("running sum wrong after first header byte");
`endif

endmodule

`default_nettype wire

/* src/psfp_digits.sv */
// Decimal split and result register for one parsed frame.
// Uses psfp_pkg helpers; drives the result interface.
`default_nettype none

module psfp_digits (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   frm_valid_i,
  output logic                  frm_ready_o,
  input  wire psfp_pkg::psfp_frame_t frm_i,
  psfp_result_if.source         res_o
);
  import psfp_pkg::*;

  logic         out_valid_q, out_valid_d;
  psfp_result_t res_q, res_d;
  psfp_digits_t d25, d10;
  logic         load;

  assign frm_ready_o = !out_valid_q || res_o.ready;
  assign load        = frm_valid_i && frm_ready_o;

  assign d25 = split_rem_f(frm_i.pm25, frm_i.pm25_hund);
  assign d10 = split_rem_f(frm_i.pm10, frm_i.pm10_hund);

  always_comb begin
    res_d.pm25_value    = frm_i.pm25;
    res_d.pm10_value    = frm_i.pm10;
    res_d.checksum_ok   = frm_i.sum_ok;
    res_d.received_sum  = frm_i.rec_sum;
    res_d.computed_sum  = frm_i.calc_sum;
    res_d.pm25_hundreds = frm_i.pm25_hund;
    res_d.pm25_tens     = d25.tens;
    res_d.pm25_ones     = d25.ones;
    res_d.pm10_hundreds = frm_i.pm10_hund;
    res_d.pm10_tens     = d10.tens;
    res_d.pm10_ones     = d10.ones;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid  = out_valid_q;
  assign res_o.result = res_q;

`ifndef NO_ASSERTIONS
  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.pm25_tens <= 4'd9 && res_q.pm25_ones <= 4'd9 &&
                     res_q.pm10_tens <= 4'd9 && res_q.pm10_ones <= 4'd9))
    else $error("decimal digit out of range");

  a_pm25_recombine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (20'(res_q.pm25_hundreds) * 20'd100 + 20'(res_q.pm25_tens) * 20'd10
                     + 20'(res_q.pm25_ones) == 20'(res_q.pm25_value)))
    else $error("PM2.5 digits do not recombine");

  a_pm10_recombine: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (20'(res_q.pm10_hundreds) * 20'd100 + 20'(res_q.pm10_tens) * 20'd10
                     + 20'(res_q.pm10_ones) == 20'(res_q.pm10_value)))
    else $error("PM10 digits do not recombine");
`endif

endmodule

`default_nettype wire

/* src/particulate_sensor_frame_parser_top.sv */
// Top level of the particulate sensor frame parser.
// Instantiates psfp_parser and psfp_digits; uses psfp_pkg and psfp_if.
//
//  channel | dir | beat payload                         | handshake
//  --------+-----+--------------------------------------+-------------------
//  rx_i    | in  | rx_byte[7:0], one serial byte        | valid/ready
//  res_o   | out | psfp_result_t, one per closed frame  | valid/ready
//
// Throughput is one byte per cycle while rx_i.ready is high; the byte
// counter, running sum and captured words update in the cycle the beat
// is taken. The last byte of a frame reaches the result through the frame
// register after the quotient-by-100 multiply, then the result register
// after the digit split. Both stages are valid/ready registers, so bytes
// keep flowing while a result waits; rx_i.ready drops only when both
// stages hold a frame and res_o is not ready. Reset (rst_ni low,
// asynchronous) clears the counter to header hunt and empties both stages.
`default_nettype none

module particulate_sensor_frame_parser_top (
  input  wire           clk_i,
  input  wire           rst_ni,
  psfp_byte_if.sink     rx_i,
  psfp_result_if.source res_o
);
  import psfp_pkg::*;

  // parsed frame record between the parser and the digit stage
  logic        frm_valid;
  logic        frm_ready;
  psfp_frame_t frm;

  psfp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx_i        (rx_i),
    .frm_valid_o (frm_valid),
    .frm_ready_i (frm_ready),
    .frm_o       (frm)
  );

  // quotient-to-digits split and the output register
  psfp_digits u_digits (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .frm_valid_i (frm_valid),
    .frm_ready_o (frm_ready),
    .frm_i       (frm),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire
